[hdl/assert_macros.svh]
// shared assertion macros, sampled on clk with synchronous reset rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hdl/ptt_pkg.sv]
package ptt_pkg;

  // results per dispatch
  localparam int MAX_RESULTS = 16;
  localparam int RES_W       = $clog2(MAX_RESULTS);

  // wall clock limits
  localparam int MS_PER_SEC   = 1000;
  localparam int SEC_PER_MIN  = 60;
  localparam int MIN_PER_HOUR = 60;
  localparam int HOUR_PER_DAY = 24;

  // operation codes
  localparam logic [2:0] MODE_TICK     = 3'd0;
  localparam logic [2:0] MODE_ADD      = 3'd1;
  localparam logic [2:0] MODE_REMOVE   = 3'd2;
  localparam logic [2:0] MODE_DISPATCH = 3'd3;
  localparam logic [2:0] MODE_SET_TIME = 3'd4;

  // result status codes
  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_REJECT = 2'd1;
  localparam logic [1:0] STATUS_NONE   = 2'd2;

  typedef struct packed {
    logic [2:0]  mode;
    logic [3:0]  slot;
    logic [15:0] period;
    logic [15:0] initial_delay;
    logic [4:0]  hour_in;
    logic [5:0]  minute_in;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] task_slot;
    logic       last;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_TICK,
    ST_SCAN,
    ST_EMIT,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic       advance;
    logic       load;
    logic [4:0] hour;
    logic [5:0] minute;
  } clk_ctl_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } wall_time_t;

endpackage

[hdl/ptt_ram.sv]
module ptt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/ptt_clock.sv]
`include "assert_macros.svh"

module ptt_clock import ptt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  clk_ctl_t   ctl,
  output wall_time_t now
);

  logic [9:0] millis, millis_next;
  logic [5:0] seconds, seconds_next;
  logic [5:0] minutes, minutes_next;
  logic [4:0] hours, hours_next;
  logic       in_range;

  // millisecond carry chain and time load with saturation
  always_comb begin
    millis_next  = millis;
    seconds_next = seconds;
    minutes_next = minutes;
    hours_next   = hours;
    if (ctl.load) begin
      hours_next   = (ctl.hour > 5'(HOUR_PER_DAY - 1)) ? 5'(HOUR_PER_DAY - 1) : ctl.hour;
      minutes_next = (ctl.minute > 6'(MIN_PER_HOUR - 1)) ? 6'(MIN_PER_HOUR - 1) : ctl.minute;
      seconds_next = '0;
    end else if (ctl.advance) begin
      if (millis == 10'(MS_PER_SEC - 1)) begin
        millis_next = '0;
        if (seconds == 6'(SEC_PER_MIN - 1)) begin
          seconds_next = '0;
          if (minutes == 6'(MIN_PER_HOUR - 1)) begin
            minutes_next = '0;
            hours_next   = (hours == 5'(HOUR_PER_DAY - 1)) ? '0 : hours + 5'd1;
          end else begin
            minutes_next = minutes + 6'd1;
          end
        end else begin
          seconds_next = seconds + 6'd1;
        end
      end else begin
        millis_next = millis + 10'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      millis  <= '0;
      seconds <= '0;
      minutes <= '0;
      hours   <= '0;
    end else begin
      millis  <= millis_next;
      seconds <= seconds_next;
      minutes <= minutes_next;
      hours   <= hours_next;
    end
  end

  assign now.hour   = hours;
  assign now.minute = minutes;
  assign now.second = seconds;

  // every counter stays inside its wrap range
  assign in_range = (millis < 10'(MS_PER_SEC)) && (seconds < 6'(SEC_PER_MIN)) &&
                    (minutes < 6'(MIN_PER_HOUR)) && (hours < 5'(HOUR_PER_DAY));

  `ASSERT_ALWAYS(a_clock_range, in_range)

endmodule

[hdl/periodic_task_timer_table.sv]
// channel | words       | handshake              | payload
// request | operations  | req_valid / req_ready  | req (req_t)
// result  | results     | rsp_valid / rsp_ready  | rsp (rsp_t)
//
// One operation at a time. Add, remove, set time and unknown codes pass through EXEC and RESP.
// A tick walks the countdown memory one slot per cycle.
// A dispatch walks the flags one slot per cycle, with an EMIT step per emitted task (period read);
// it stops at the last due slot or at MAX_RESULTS results; with nothing due it answers STATUS_NONE.
// Reset clears the slot flags and the clock; no clearing pass.
// A stalled result holds the walk; the next request is taken once the last result is loaded.
`include "assert_macros.svh"

module periodic_task_timer_table import ptt_pkg::*; #(
  parameter int NUM_SLOTS   = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W = IDX_W + 1;

  state_t                 state, state_next;
  req_t                   op;
  logic [NUM_SLOTS-1:0]   slot_valid, slot_valid_next;
  logic [NUM_SLOTS-1:0]   slot_ready, slot_ready_next;
  logic [CNT_W-1:0]       walk;
  logic                   rd_vld;
  logic [IDX_W-1:0]       rd_idx;
  logic [RES_W-1:0]       emitted;
  logic [1:0]             status_q, status_next;

  logic [IDX_W-1:0]       op_idx, walk_idx;
  logic                   op_in_range, walk_done, out_free, more_due, emit_last;
  logic [NUM_SLOTS-1:0]   due;
  logic                   cd_we, per_we, out_load;
  logic [IDX_W-1:0]       cd_waddr;
  logic [COUNT_WIDTH-1:0] cd_wdata, cd_rdata, per_rdata;
  rsp_t                   out_word;
  clk_ctl_t               clk_ctl;
  wall_time_t             now;

  // slot state memories
  ptt_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(NUM_SLOTS)) u_countdown (
    .clk   (clk),
    .we    (cd_we),
    .waddr (cd_waddr),
    .wdata (cd_wdata),
    .raddr (walk_idx),
    .rdata (cd_rdata)
  );

  ptt_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(NUM_SLOTS)) u_period (
    .clk   (clk),
    .we    (per_we),
    .waddr (op_idx),
    .wdata (COUNT_WIDTH'(op.period)),
    .raddr (walk_idx),
    .rdata (per_rdata)
  );

  ptt_clock u_clock (
    .clk (clk),
    .rst (rst),
    .ctl (clk_ctl),
    .now (now)
  );

  // shared decode
  assign op_idx      = IDX_W'(op.slot);
  assign op_in_range = int'(op.slot) < NUM_SLOTS;
  assign walk_idx    = walk[IDX_W-1:0];
  assign walk_done   = (walk == CNT_W'(NUM_SLOTS));
  assign out_free    = !rsp_valid || rsp_ready;
  assign due         = slot_valid & slot_ready;
  assign more_due    = |((due >> walk_idx) >> 1);
  assign emit_last   = !more_due || (emitted == RES_W'(MAX_RESULTS - 1));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (op.mode == MODE_TICK) state_next = ST_TICK;
        else if (op.mode == MODE_DISPATCH) state_next = ST_SCAN;
        else state_next = ST_RESP;
      end
      ST_TICK: begin
        if (walk_done && !rd_vld) state_next = ST_RESP;
      end
      ST_SCAN: begin
        if (walk_done) state_next = ST_RESP;
        else if (due[walk_idx]) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) state_next = emit_last ? ST_IDLE : ST_SCAN;
      end
      ST_RESP: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    req_ready      = (state == ST_IDLE);
    cd_we          = 1'b0;
    cd_waddr       = rd_idx;
    cd_wdata       = cd_rdata - COUNT_WIDTH'(1);
    per_we         = 1'b0;
    out_load       = 1'b0;
    out_word       = '0;
    out_word.hour   = now.hour;
    out_word.minute = now.minute;
    out_word.second = now.second;
    status_next    = status_q;
    clk_ctl        = '0;
    clk_ctl.hour   = op.hour_in;
    clk_ctl.minute = op.minute_in;
    case (state)
      ST_EXEC: begin
        status_next = STATUS_OK;
        case (op.mode)
          MODE_TICK: clk_ctl.advance = 1'b1;
          MODE_ADD: begin
            if (!op_in_range || slot_valid[op_idx]) begin
              status_next = STATUS_REJECT;
            end else begin
              per_we   = 1'b1;
              cd_we    = 1'b1;
              cd_waddr = op_idx;
              cd_wdata = COUNT_WIDTH'(op.initial_delay);
            end
          end
          MODE_REMOVE: begin
            if (!op_in_range) status_next = STATUS_REJECT;
          end
          MODE_DISPATCH: status_next = STATUS_OK;
          MODE_SET_TIME: clk_ctl.load = 1'b1;
          default: status_next = STATUS_REJECT;
        endcase
      end
      ST_TICK: begin
        cd_we = rd_vld && slot_valid[rd_idx] && (cd_rdata != '0);
      end
      ST_SCAN: begin
        if (walk_done) status_next = STATUS_NONE;
      end
      ST_EMIT: begin
        out_load           = out_free;
        out_word.status    = STATUS_OK;
        out_word.task_slot = 4'(walk_idx);
        out_word.last      = emit_last;
        cd_we              = out_free && (per_rdata != '0);
        cd_waddr           = walk_idx;
        cd_wdata           = per_rdata;
      end
      ST_RESP: begin
        out_load        = out_free;
        out_word.status = status_q;
        out_word.last   = 1'b1;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  // slot flag updates
  always_comb begin
    slot_valid_next = slot_valid;
    slot_ready_next = slot_ready;
    case (state)
      ST_EXEC: begin
        if (op.mode == MODE_ADD && op_in_range && !slot_valid[op_idx]) begin
          slot_valid_next[op_idx] = 1'b1;
          slot_ready_next[op_idx] = 1'b0;
        end else if (op.mode == MODE_REMOVE && op_in_range) begin
          slot_valid_next[op_idx] = 1'b0;
          slot_ready_next[op_idx] = 1'b0;
        end
      end
      ST_TICK: begin
        if (rd_vld && slot_valid[rd_idx] && (cd_rdata == '0)) begin
          slot_ready_next[rd_idx] = 1'b1;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          slot_ready_next[walk_idx] = 1'b0;
          if (per_rdata == '0) slot_valid_next[walk_idx] = 1'b0;
        end
      end
      default: begin
        slot_valid_next = slot_valid;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      slot_valid <= '0;
      slot_ready <= '0;
      walk       <= '0;
      rd_vld     <= 1'b0;
      emitted    <= '0;
      status_q   <= STATUS_OK;
      rsp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      slot_valid <= slot_valid_next;
      slot_ready <= slot_ready_next;
      status_q   <= status_next;
      rd_vld     <= (state == ST_TICK) && !walk_done;
      if (state == ST_EXEC) begin
        walk    <= '0;
        emitted <= '0;
      end else if (state == ST_TICK && !walk_done) begin
        walk <= walk + CNT_W'(1);
      end else if (state == ST_SCAN && !walk_done && !due[walk_idx]) begin
        walk <= walk + CNT_W'(1);
      end else if (state == ST_EMIT && out_free) begin
        walk    <= walk + CNT_W'(1);
        emitted <= emitted + RES_W'(1);
      end
      if (out_load) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_idx <= walk_idx;
    if (req_valid && req_ready) op <= req;
    if (out_load) rsp <= out_word;
  end

  // a ready flag never stands on a free slot
  `ASSERT_ALWAYS(a_ready_needs_valid, (slot_ready & ~slot_valid) == '0)
  // a pending result is never overwritten
  `ASSERT_IMPLIES(a_no_overrun, rsp_valid && !rsp_ready, !out_load)
  // an emitted slot is one that is due
  `ASSERT_IMPLIES(a_emit_due, state == ST_EMIT, due[walk_idx])
  // countdown reads come back only during the tick walk
  `ASSERT_NEXT(a_walk_read, rd_vld, (state == ST_TICK) || (state == ST_RESP))

endmodule

[tb/sv/periodic_task_timer_table_tb.sv]
module periodic_task_timer_table_tb;
  import ptt_pkg::*;

  localparam int NUM_SLOTS = 16;

  // codes the block does not define, answered with a reject
  localparam logic [2:0] MODE_UNUSED_LO  = 3'd5;
  localparam logic [2:0] MODE_UNUSED_MID = 3'd6;
  localparam logic [2:0] MODE_UNUSED_HI  = 3'd7;

  typedef struct {
    req_t op;
    bit   typed;
    rsp_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  // own copy of the task table and the wall clock
  bit          tbl_valid [NUM_SLOTS];
  bit          tbl_ready [NUM_SLOTS];
  logic [15:0] tbl_period [NUM_SLOTS];
  logic [15:0] tbl_count [NUM_SLOTS];
  int          clk_ms;
  int          clk_sec;
  int          clk_min;
  int          clk_hr;

  rsp_t fresh_rsp [$];
  rsp_t awaited_rsp [$];
  int   err_count = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;

  periodic_task_timer_table uut (
    .clk,
    .rst,
    .req_valid,
    .req_ready,
    .req,
    .rsp_valid,
    .rsp_ready,
    .rsp
  );

  always #5 clk = ~clk;

  // result side back-pressure
  always @(negedge clk) begin
    rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  function automatic req_t mk_op(logic [2:0] mode, int slot, int period, int delay,
                                 int hr, int mn);
    req_t op;
    op.mode          = mode;
    op.slot          = 4'(slot);
    op.period        = 16'(period);
    op.initial_delay = 16'(delay);
    op.hour_in       = 5'(hr);
    op.minute_in     = 6'(mn);
    return op;
  endfunction

  function automatic rsp_t mk_rsp(logic [1:0] status, int slot, bit last, int hr, int mn,
                                  int sec);
    rsp_t r;
    r.status    = status;
    r.task_slot = 4'(slot);
    r.last      = last;
    r.hour      = 5'(hr);
    r.minute    = 6'(mn);
    r.second    = 6'(sec);
    return r;
  endfunction

  // advance the table by one operation and collect the words it answers with
  function automatic void table_step(input req_t op);
    int         i;
    int         n;
    logic [1:0] status;
    status = STATUS_OK;
    fresh_rsp.delete();
    case (op.mode)
      MODE_TICK: begin
        clk_ms++;
        if (clk_ms >= MS_PER_SEC) begin
          clk_ms = 0;
          clk_sec++;
          if (clk_sec >= SEC_PER_MIN) begin
            clk_sec = 0;
            clk_min++;
            if (clk_min >= MIN_PER_HOUR) begin
              clk_min = 0;
              clk_hr++;
              if (clk_hr >= HOUR_PER_DAY) clk_hr = 0;
            end
          end
        end
        // countdowns already at zero turn ready, the rest count down
        for (i = 0; i < NUM_SLOTS; i++) begin
          if (tbl_valid[i]) begin
            if (tbl_count[i] != 0) tbl_count[i]--;
            else tbl_ready[i] = 1'b1;
          end
        end
      end
      MODE_ADD: begin
        if (int'(op.slot) >= NUM_SLOTS || tbl_valid[op.slot]) begin
          status = STATUS_REJECT;
        end else begin
          tbl_valid[op.slot]  = 1'b1;
          tbl_ready[op.slot]  = 1'b0;
          tbl_period[op.slot] = op.period;
          tbl_count[op.slot]  = op.initial_delay;
        end
      end
      MODE_REMOVE: begin
        if (int'(op.slot) >= NUM_SLOTS) begin
          status = STATUS_REJECT;
        end else begin
          tbl_valid[op.slot] = 1'b0;
          tbl_ready[op.slot] = 1'b0;
        end
      end
      MODE_DISPATCH: begin
        n = 0;
        for (i = 0; i < NUM_SLOTS && n < MAX_RESULTS; i++) begin
          if (tbl_valid[i] && tbl_ready[i]) begin
            // periodic tasks reload, one-shot tasks leave the table
            if (tbl_period[i] != 0) tbl_count[i] = tbl_period[i];
            else tbl_valid[i] = 1'b0;
            tbl_ready[i] = 1'b0;
            fresh_rsp.push_back(mk_rsp(STATUS_OK, i, 1'b0, clk_hr, clk_min, clk_sec));
            n++;
          end
        end
        if (n == 0) fresh_rsp.push_back(mk_rsp(STATUS_NONE, 0, 1'b1, clk_hr, clk_min, clk_sec));
        else fresh_rsp[n-1].last = 1'b1;
        return;
      end
      MODE_SET_TIME: begin
        clk_hr  = (op.hour_in > HOUR_PER_DAY - 1) ? HOUR_PER_DAY - 1 : int'(op.hour_in);
        clk_min = (op.minute_in > MIN_PER_HOUR - 1) ? MIN_PER_HOUR - 1 : int'(op.minute_in);
        clk_sec = 0;
      end
      default: begin
        status = STATUS_REJECT;
      end
    endcase
    fresh_rsp.push_back(mk_rsp(status, 0, 1'b1, clk_hr, clk_min, clk_sec));
  endfunction

  task automatic report_err(input string msg);
    if (err_count < 30) $display("ERROR at %0t: %s", $time, msg);
    err_count++;
  endtask

  task automatic chk_field(input string name, input int got, input int want);
    if (got != want) report_err($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // offer one word, wait for acceptance, then record what it should produce
  task automatic send_op(input req_t op, input bit typed = 1'b0, input rsp_t want = '0);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= op;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    table_step(op);
    if (typed) awaited_rsp.push_back(want);
    else foreach (fresh_rsp[k]) awaited_rsp.push_back(fresh_rsp[k]);
    @(negedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (awaited_rsp.size() == 0) begin
        report_err($sformatf("result word %h with none expected", rsp));
      end else begin
        want = awaited_rsp.pop_front();
        chk_field("status", rsp.status, want.status);
        chk_field("task_slot", rsp.task_slot, want.task_slot);
        chk_field("last", rsp.last, want.last);
        chk_field("hour", rsp.hour, want.hour);
        chk_field("minute", rsp.minute, want.minute);
        chk_field("second", rsp.second, want.second);
      end
    end
  end

  // run time limit
  initial begin
    #80_000_000;
    $display("periodic_task_timer_table_tb NOT OK");
    $finish;
  end

  initial begin
    dir_row_t dir_rows [$];
    req_t     op;
    int       ph;
    int       sent;
    int       r;
    int       idle_set [4];
    int       stall_set [4];

    idle_set  = '{0, 54, 0, 35};
    stall_set = '{0, 0, 54, 35};
    foreach (tbl_valid[i]) begin
      tbl_valid[i]  = 1'b0;
      tbl_ready[i]  = 1'b0;
      tbl_period[i] = '0;
      tbl_count[i]  = '0;
    end
    clk_ms  = 0;
    clk_sec = 0;
    clk_min = 0;
    clk_hr  = 0;

    // directed rows: empty table, unknown codes, time saturation, one-shot and periodic tasks
    dir_rows.push_back('{mk_op(MODE_DISPATCH, 0, 0, 0, 0, 0), 1'b1,
                         mk_rsp(STATUS_NONE, 0, 1'b1, 0, 0, 0)});
    dir_rows.push_back('{mk_op(MODE_UNUSED_LO, 0, 0, 0, 0, 0), 1'b1,
                         mk_rsp(STATUS_REJECT, 0, 1'b1, 0, 0, 0)});
    dir_rows.push_back('{mk_op(MODE_UNUSED_MID, 15, 65535, 65535, 31, 63), 1'b1,
                         mk_rsp(STATUS_REJECT, 0, 1'b1, 0, 0, 0)});
    dir_rows.push_back('{mk_op(MODE_UNUSED_HI, 0, 0, 0, 0, 0), 1'b1,
                         mk_rsp(STATUS_REJECT, 0, 1'b1, 0, 0, 0)});
    dir_rows.push_back('{mk_op(MODE_SET_TIME, 0, 0, 0, 31, 63), 1'b1,
                         mk_rsp(STATUS_OK, 0, 1'b1, 23, 59, 0)});
    dir_rows.push_back('{mk_op(MODE_SET_TIME, 0, 0, 0, 0, 0), 1'b1,
                         mk_rsp(STATUS_OK, 0, 1'b1, 0, 0, 0)});
    dir_rows.push_back('{mk_op(MODE_REMOVE, 3, 0, 0, 0, 0), 1'b1,
                         mk_rsp(STATUS_OK, 0, 1'b1, 0, 0, 0)});
    dir_rows.push_back('{mk_op(MODE_ADD, 0, 0, 0, 0, 0), 1'b1,
                         mk_rsp(STATUS_OK, 0, 1'b1, 0, 0, 0)});
    dir_rows.push_back('{mk_op(MODE_ADD, 0, 5, 5, 0, 0), 1'b1,
                         mk_rsp(STATUS_REJECT, 0, 1'b1, 0, 0, 0)});
    dir_rows.push_back('{mk_op(MODE_ADD, 15, 65535, 65535, 0, 0), 1'b1,
                         mk_rsp(STATUS_OK, 0, 1'b1, 0, 0, 0)});
    dir_rows.push_back('{mk_op(MODE_ADD, 1, 2, 1, 0, 0), 1'b1,
                         mk_rsp(STATUS_OK, 0, 1'b1, 0, 0, 0)});
    dir_rows.push_back('{mk_op(MODE_TICK, 0, 0, 0, 0, 0), 1'b1,
                         mk_rsp(STATUS_OK, 0, 1'b1, 0, 0, 0)});
    dir_rows.push_back('{mk_op(MODE_DISPATCH, 0, 0, 0, 0, 0), 1'b0, '0});
    dir_rows.push_back('{mk_op(MODE_TICK, 0, 0, 0, 0, 0), 1'b0, '0});
    dir_rows.push_back('{mk_op(MODE_DISPATCH, 0, 0, 0, 0, 0), 1'b0, '0});
    dir_rows.push_back('{mk_op(MODE_TICK, 0, 0, 0, 0, 0), 1'b0, '0});
    dir_rows.push_back('{mk_op(MODE_DISPATCH, 0, 0, 0, 0, 0), 1'b0, '0});
    dir_rows.push_back('{mk_op(MODE_ADD, 2, 0, 0, 0, 0), 1'b1,
                         mk_rsp(STATUS_OK, 0, 1'b1, 0, 0, 0)});
    dir_rows.push_back('{mk_op(MODE_ADD, 7, 1, 0, 0, 0), 1'b1,
                         mk_rsp(STATUS_OK, 0, 1'b1, 0, 0, 0)});
    dir_rows.push_back('{mk_op(MODE_TICK, 0, 0, 0, 0, 0), 1'b0, '0});
    dir_rows.push_back('{mk_op(MODE_DISPATCH, 0, 0, 0, 0, 0), 1'b0, '0});
    dir_rows.push_back('{mk_op(MODE_REMOVE, 15, 0, 0, 0, 0), 1'b1,
                         mk_rsp(STATUS_OK, 0, 1'b1, 0, 0, 0)});
    dir_rows.push_back('{mk_op(MODE_REMOVE, 1, 0, 0, 0, 0), 1'b1,
                         mk_rsp(STATUS_OK, 0, 1'b1, 0, 0, 0)});
    dir_rows.push_back('{mk_op(MODE_DISPATCH, 0, 0, 0, 0, 0), 1'b0, '0});

    // synchronous reset, released on a falling edge
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[k]) send_op(dir_rows[k].op, dir_rows[k].typed, dir_rows[k].want);

    // random words in four idling phases
    for (ph = 0; ph < 4; ph++) begin
      send_idle_pct  = idle_set[ph];
      recv_stall_pct = stall_set[ph];
      sent = 0;
      while (sent < 120) begin
        if ($urandom_range(0, 29) == 0) begin
          // fill every free slot with short delays, let them mature, then drain
          for (int s = 0; s < NUM_SLOTS; s++) begin
            if (!tbl_valid[s] || $urandom_range(0, 7) == 0) begin
              send_op(mk_op(MODE_ADD, s, $urandom_range(0, 3), $urandom_range(0, 2), 0, 0));
              sent++;
            end
          end
          repeat (3) send_op(mk_op(MODE_TICK, 0, 0, 0, 0, 0));
          repeat (2) send_op(mk_op(MODE_DISPATCH, 0, 0, 0, 0, 0));
          sent += 5;
        end else begin
          // random don't-care fields on every word
          op.slot          = 4'($urandom_range(0, 15));
          op.period        = 16'($urandom);
          op.initial_delay = 16'($urandom);
          op.hour_in       = 5'($urandom_range(0, 31));
          op.minute_in     = 6'($urandom_range(0, 63));
          r = $urandom_range(0, 99);
          if (r < 40) begin
            op.mode = MODE_TICK;
          end else if (r < 58) begin
            op.mode = MODE_ADD;
            if ($urandom_range(0, 4) != 0) op.period = 16'($urandom_range(0, 5));
            if ($urandom_range(0, 4) != 0) op.initial_delay = 16'($urandom_range(0, 4));
          end else if (r < 66) begin
            op.mode = MODE_REMOVE;
          end else if (r < 90) begin
            op.mode = MODE_DISPATCH;
          end else if (r < 96) begin
            op.mode = MODE_SET_TIME;
          end else begin
            op.mode = 3'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
          end
          send_op(op);
          sent++;
        end
      end
    end

    // drain and let the block settle
    req_valid <= 1'b0;
    while (awaited_rsp.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (err_count == 0) begin
      $display("periodic_task_timer_table_tb OK");
    end else begin
      $display("periodic_task_timer_table_tb NOT OK");
    end
    $finish;
  end

endmodule
